FILE: sv/sdf_pkg.sv
`default_nettype none

package sdf_pkg;

    // Field widths of the ports.
    localparam int VALUE_W = 25;
    localparam int CHAR_W  = 8;

    // The magnitude of a 25-bit two's complement value fits in 25 bits.
    localparam int MAG_W = VALUE_W;

    // Digit counts run from 1 to at most 10, which fits in 4 bits.
    localparam int DIG_W = 4;

    // Default number of digits before saturation.
    localparam int MAX_DIGITS_DEF = 7;

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    // One classified number on its way to the back end.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [DIG_W-1:0] ndig;
    } t_item;

    // Ten to the power n, for n up to 10.
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < 10; k++) begin
            if (k < n) begin
                p = p * 64'd10;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: sv/signed_decimal_formatter_core.sv
// Formats one signed 25-bit integer per transaction as ASCII decimal text,
// one character per cycle on o_character with o_strobe high, most significant
// digit first, a leading minus sign for negative values, no leading zeros, and
// o_last on the final digit; magnitudes above 10^MAX_DIGITS - 1 saturate to
// that bound. The receiver cannot stall: every strobed character must be taken
// in its cycle. Each transaction yields a minus sign if negative, then one
// character per digit, 1 to MAX_DIGITS + 1 characters in all; the digit
// sequencer in the back end emits exactly one per clock while a number goes
// out. The first character goes through the input register, the queue, the
// digit sequencer and the output register; the two-entry queue between the
// classifying front end and the sequencer lets new transactions be taken while
// a number goes out; busy rises only when queue and input register are full.

`default_nettype none

module signed_decimal_formatter_core #(
    parameter int MAX_DIGITS = sdf_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [sdf_pkg::VALUE_W-1:0] i_value,
    output logic                                    o_strobe,
    output logic [sdf_pkg::CHAR_W-1:0]              o_character,
    output logic                                    o_last
);
    import sdf_pkg::*;

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    t_item front_item;
    t_item head_item;

    // Front end: input register, sign, magnitude and digit count.
    sdf_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_value  (VALUE_W'(i_value)),
        .i_q_full (q_full),
        .o_busy   (busy),
        .o_push   (push),
        .o_item   (front_item)
    );

    // Queue between the two halves.
    sdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    // Back end: one character per cycle.
    sdf_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

FILE: sv/sdf_front.sv
`default_nettype none

module sdf_front #(
    parameter int MAX_DIGITS = sdf_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [sdf_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                         i_q_full,
    output logic                              o_busy,
    output logic                              o_push,
    output sdf_pkg::t_item                    o_item
);
    import sdf_pkg::*;

    // Largest magnitude that can be shown.
    localparam logic [63:0] LIMIT = pow10(MAX_DIGITS) - 64'd1;

    logic               r_valid;
    logic [VALUE_W-1:0] r_value;
    logic               accept;
    logic               neg;
    logic [MAG_W-1:0]   abs_mag;
    logic [63:0]        ext_mag;
    logic               sat;
    logic [DIG_W-1:0]   ndig;

    // The input register is held while the queue is full.
    assign o_busy = r_valid && i_q_full;
    assign o_push = r_valid && !i_q_full;
    assign accept = i_start && !o_busy;

    // Input register for one transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= i_value;
        end
    end

    // Sign, magnitude, saturation and digit count.
    always_comb begin
        neg     = r_value[VALUE_W-1];
        abs_mag = neg ? (MAG_W'(~r_value) + MAG_W'(1)) : MAG_W'(r_value);
        ext_mag = 64'(abs_mag);
        sat     = ext_mag > LIMIT;
        ndig    = DIG_W'(1);
        for (int k = 1; k < MAX_DIGITS; k++) begin
            if (ext_mag >= pow10(k)) begin
                ndig = ndig + DIG_W'(1);
            end
        end
        if (sat) begin
            ndig = DIG_W'(MAX_DIGITS);
        end
        o_item.neg  = neg;
        o_item.mag  = sat ? LIMIT[MAG_W-1:0] : abs_mag;
        o_item.ndig = ndig;
    end

endmodule

`default_nettype wire

FILE: sv/sdf_queue.sv
`default_nettype none

module sdf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sdf_pkg::t_item  i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output sdf_pkg::t_item       o_item
);
    import sdf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/sdf_back.sv
`default_nettype none

module sdf_back #(
    parameter int MAX_DIGITS = sdf_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire sdf_pkg::t_item              i_item,
    output logic                             o_pop,
    output logic                             o_strobe,
    output logic [sdf_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_last
);
    import sdf_pkg::*;

    logic               r_active;
    logic               r_neg;
    logic [MAG_W-1:0]   r_mag;
    logic [DIG_W-1:0]   r_pos;
    logic               r_strobe;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic [63:0]        mult [1:9];
    logic [63:0]        ext_mag;
    logic [63:0]        sel;
    logic [63:0]        rem;
    logic [3:0]         digit;
    logic               done;
    logic [CHAR_W-1:0]  n_char;
    logic               n_last;

    // The number is finished when the units digit goes out.
    assign done  = r_active && !r_neg && (r_pos == DIG_W'(1));
    assign o_pop = i_q_valid && (!r_active || done);

    // Multiples of the weight of the current digit position.
    always_comb begin
        for (int k = 1; k <= 9; k++) begin
            mult[k] = '0;
        end
        for (int j = 0; j < MAX_DIGITS; j++) begin
            if (r_pos == DIG_W'(j + 1)) begin
                for (int k = 1; k <= 9; k++) begin
                    mult[k] = 64'(k) * pow10(j);
                end
            end
        end
    end

    // Digit value by comparison against the multiples, then the remainder.
    always_comb begin
        ext_mag = 64'(r_mag);
        digit   = '0;
        sel     = '0;
        for (int k = 1; k <= 9; k++) begin
            if (ext_mag >= mult[k]) begin
                digit = 4'(k);
                sel   = mult[k];
            end
        end
        rem = ext_mag - sel;
        if (r_neg) begin
            n_char = CHAR_MINUS;
            n_last = 1'b0;
        end else begin
            n_char = CHAR_ZERO + {4'b0000, digit};
            n_last = r_pos == DIG_W'(1);
        end
    end

    // Digit sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_neg    <= 1'b0;
            r_pos    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_neg    <= i_item.neg;
            r_pos    <= i_item.ndig;
        end else if (r_active) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else if (done) begin
                r_active <= 1'b0;
            end else begin
                r_pos <= r_pos - DIG_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mag <= i_item.mag;
        end else if (r_active && !r_neg) begin
            r_mag <= rem[MAG_W-1:0];
        end
    end

    // Output register: one character per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last && r_strobe;

endmodule

`default_nettype wire

FILE: bench/sdf_text_checker.sv
module sdf_text_checker #(
    parameter int MAX_DIGITS = sdf_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_busy,
    input  wire logic [sdf_pkg::VALUE_W-1:0] i_value,
    input  wire logic                        i_strobe,
    input  wire logic [sdf_pkg::CHAR_W-1:0]  i_character,
    input  wire logic                        i_last,
    output int                               o_fail_count,
    output int                               o_chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted character, tagged with the number it came from.
    typedef struct packed {
        logic [sdf_pkg::VALUE_W-1:0] src;
        logic [sdf_pkg::CHAR_W-1:0]  chr;
        logic                        last;
    } t_char_exp;

    t_char_exp expected_chars[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic void push_char(input logic [sdf_pkg::VALUE_W-1:0] src,
                                      input logic [sdf_pkg::CHAR_W-1:0] chr,
                                      input logic last);
        t_char_exp c;
        c.src  = src;
        c.chr  = chr;
        c.last = last;
        expected_chars.push_back(c);
    endfunction

    // Works out the decimal text of one number: sign, then digits without
    // leading zeros, with the magnitude clamped to the largest MAX_DIGITS value.
    function automatic void predict_text(input logic [sdf_pkg::VALUE_W-1:0] raw);
        logic                        neg;
        logic [sdf_pkg::VALUE_W-1:0] mag;
        longint unsigned             m;
        longint unsigned             ceiling;
        longint unsigned             div;
        longint unsigned             d;
        bit                          started;
        neg     = raw[sdf_pkg::VALUE_W-1];
        mag     = neg ? (~raw + 1'b1) : raw;
        ceiling = 1;
        repeat (MAX_DIGITS) ceiling = ceiling * 10;
        ceiling = ceiling - 1;
        m       = mag;
        if (m > ceiling) begin
            m = ceiling;
        end
        if (m == 0) begin
            push_char(raw, sdf_pkg::CHAR_ZERO, 1'b1);
            return;
        end
        if (neg) begin
            push_char(raw, sdf_pkg::CHAR_MINUS, 1'b0);
        end
        div     = (ceiling + 1) / 10;
        started = 0;
        for (int i = MAX_DIGITS; i > 0; i--) begin
            d = m / div;
            m = m % div;
            if (d != 0) begin
                started = 1;
            end
            if (started) begin
                push_char(raw, sdf_pkg::CHAR_ZERO + d[sdf_pkg::CHAR_W-1:0], i == 1);
            end
            div = div / 10;
        end
    endfunction

    // Predict on every accepted transaction, and check every strobed character
    // against the oldest prediction. Reset clears the predictions and the count.
    always @(posedge i_clk) begin
        t_char_exp want;
        if (!i_rst_n) begin
            expected_chars.delete();
            o_fail_count = 0;
        end else begin
            if (i_start && !i_busy) begin
                predict_text(i_value);
            end
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                              i_character, i_last));
                end else begin
                    want = expected_chars.pop_front();
                    if (i_character !== want.chr) begin
                        report_mismatch($sformatf("value %0d: character 0x%02h, want 0x%02h",
                                                  $signed(want.src), i_character, want.chr));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("value %0d: last %0b, want %0b",
                                                  $signed(want.src), i_last, want.last));
                    end
                end
            end
        end
        o_chars_pending = expected_chars.size();
    end

endmodule

FILE: bench/tb_signed_decimal_formatter_core.sv
module tb_signed_decimal_formatter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_NUMBERS = 250;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic signed [sdf_pkg::VALUE_W-1:0] i_value;
    logic                               o_strobe;
    logic [sdf_pkg::CHAR_W-1:0]         o_character;
    logic                               o_last;

    int fail_count;
    int chars_pending;
    int idle_cycles = 0;

    // Edge cases: zero, single digits, powers of ten, the saturation
    // boundary on both sides, and the most extreme 25-bit values.
    int directed_values[] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 1000000, -1000000,
        1234567, -7654321, 9090909, 9999999, -9999999, 10000000, -10000000,
        16777215, -16777216, 5000000, -20, 7
    };

    signed_decimal_formatter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    sdf_text_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_value         (i_value),
        .i_strobe        (o_strobe),
        .i_character     (o_character),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Watchdog: ends the run if neither side moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("signed_decimal_formatter_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Draws a number: mostly a random digit count with a random sign, some zeros,
    // some values near the saturation bound, and some full-width bit patterns.
    function automatic logic [sdf_pkg::VALUE_W-1:0] random_number();
        int unsigned kind;
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        int unsigned word;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            word = $urandom();
            return word[sdf_pkg::VALUE_W-1:0];
        end
        if (kind == 2) begin
            mag = $urandom_range(9999990, 10000010);
        end else if (kind == 3 && $urandom_range(0, 3) == 0) begin
            mag = 0;
        end else begin
            ndig = $urandom_range(1, sdf_pkg::MAX_DIGITS_DEF);
            hi   = 1;
            repeat (ndig) hi = hi * 10;
            lo   = (ndig == 1) ? 1 : hi / 10;
            mag  = $urandom_range(lo, hi - 1);
        end
        word = $urandom_range(0, 1) ? -mag : mag;
        return word[sdf_pkg::VALUE_W-1:0];
    endfunction

    // Offers one number after a gap and holds it until it is accepted.
    // Called at a rising edge; returns at the accepting edge.
    task automatic send_number(input logic [sdf_pkg::VALUE_W-1:0] v, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        bit burst;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed numbers, back to back and with short gaps.
        foreach (directed_values[k]) begin
            send_number(directed_values[k][sdf_pkg::VALUE_W-1:0],
                        (k < 12) ? 0 : $urandom_range(0, 5));
        end

        // Random numbers; every sixteen transactions pick a burst stretch
        // with no gaps or a stretch with random gaps.
        burst = 0;
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            if (n % 16 == 0) begin
                burst = ($urandom_range(0, 2) == 0);
            end
            send_number(random_number(), burst ? 0 : $urandom_range(0, 5));
        end
        start <= 1'b0;

        // Wait for every predicted character, then a little longer to catch
        // anything extra.
        @(negedge i_clk);
        while (chars_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0) begin
            $display("signed_decimal_formatter_core regression: pass");
        end else begin
            $display("signed_decimal_formatter_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: signed_decimal_formatter_core.f
sv/sdf_pkg.sv
sv/sdf_front.sv
sv/sdf_queue.sv
sv/sdf_back.sv
sv/signed_decimal_formatter_core.sv
bench/sdf_text_checker.sv
bench/tb_signed_decimal_formatter_core.sv
